[src/kvt_pkg.sv]
// kvt_pkg: sizes, payload types and codes for the key/value table.
// Used by the channel interfaces and key_value_table.
// No dependencies.
package kvt_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_VDATA,
    S_OUT
  } state_t;

endpackage

[src/kvt_req_if.sv]
// kvt_req_if: request channel of the key/value table (valid/ready plus payload).
// Depends on kvt_pkg for the payload types.
interface kvt_req_if;
  logic              valid;
  logic              ready;
  kvt_pkg::op_kind_t kind;
  kvt_pkg::key_t     key;
  kvt_pkg::value_t   value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

[src/kvt_rsp_if.sv]
// kvt_rsp_if: result channel of the key/value table (valid/ready plus payload).
// Depends on kvt_pkg for the payload types.
interface kvt_rsp_if;
  logic             valid;
  logic             ready;
  kvt_pkg::value_t  read_value;
  kvt_pkg::status_t status;
  kvt_pkg::count_t  entry_count;
  logic             is_empty;

  modport source (output valid, output read_value, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  input is_empty, output ready);
endinterface

[src/kvt_ram.sv]
// kvt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/key_value_table.sv]
// key_value_table: associative table of up to ENTRIES key/value pairs.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if and kvt_ram.
//
// Usage:
//   in_ch  carries one operation per item: put, remove, get or clear, with a
//          key and (for put) a value. valid/ready handshake.
//   out_ch returns exactly one result item per request: read value (get
//          only, else zero), status (ok / not found / full), entry count and
//          empty flag after the operation.
// Keys and values live in two RAMs. put, remove and get sweep the key RAM
// one slot per cycle (the RAM read is registered, so each key is compared in
// the cycle after its address) and stop at the first valid match; the lowest
// free slot is noted during the sweep. One item is in work at a time, so the
// sweep of the key RAM sets the throughput.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver only holds up the item after that.
// Reset (synchronous, active low) empties the table at once: valid bits and
// the count clear, RAM contents are left as they are.
module key_value_table (
  input logic         clk,
  input logic         rst_n,
  kvt_req_if.sink     in_ch,
  kvt_rsp_if.source   out_ch
);

  localparam kvt_pkg::idx_t   IDX_LAST  = kvt_pkg::idx_t'(kvt_pkg::ENTRIES - 1);
  localparam kvt_pkg::count_t CNT_FULL  = kvt_pkg::count_t'(kvt_pkg::ENTRIES);

  kvt_pkg::state_t state_r, state_nxt;

  // latched request
  kvt_pkg::op_kind_t kind_r;
  kvt_pkg::key_t     key_r;
  kvt_pkg::value_t   value_r;

  // sweep
  kvt_pkg::idx_t scan_idx_r, scan_idx_nxt;
  logic          issue_r, issue_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  kvt_pkg::idx_t cmp_idx_r, cmp_idx_nxt;
  logic          cmp_last_r, cmp_last_nxt;
  logic          hit_r, hit_nxt;
  kvt_pkg::idx_t slot_r, slot_nxt;
  logic          free_found_r, free_found_nxt;
  kvt_pkg::idx_t free_idx_r, free_idx_nxt;

  // table state outside the RAMs
  logic [kvt_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  kvt_pkg::count_t             count_r, count_nxt;

  // pending result
  kvt_pkg::value_t  rd_r, rd_nxt;
  kvt_pkg::status_t st_r, st_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  kvt_pkg::value_t  out_value_r, out_value_nxt;
  kvt_pkg::status_t out_status_r, out_status_nxt;
  kvt_pkg::count_t  out_count_r, out_count_nxt;
  logic             out_empty_r, out_empty_nxt;

  // RAM ports
  logic            key_wr_en, val_wr_en, key_rd_en, val_rd_en;
  kvt_pkg::idx_t   wr_addr, key_rd_addr, val_rd_addr;
  kvt_pkg::key_t   key_rd_data;
  kvt_pkg::value_t val_rd_data;

  logic accept;

  assign in_ch.ready = (state_r == kvt_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  kvt_ram #(.WIDTH(kvt_pkg::KEY_BITS), .DEPTH(kvt_pkg::ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_r),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  kvt_ram #(.WIDTH(kvt_pkg::VALUE_BITS), .DEPTH(kvt_pkg::ENTRIES)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (val_rd_en),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_last_nxt   = cmp_last_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    rd_nxt         = rd_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    key_wr_en      = 1'b0;
    val_wr_en      = 1'b0;
    key_rd_en      = 1'b0;
    val_rd_en      = 1'b0;
    wr_addr        = slot_r;
    key_rd_addr    = scan_idx_r;
    val_rd_addr    = slot_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      kvt_pkg::S_IDLE: begin
        if (accept) begin
          scan_idx_nxt   = '0;
          issue_nxt      = 1'b1;
          cmp_vld_nxt    = 1'b0;
          cmp_last_nxt   = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt = (in_ch.kind == kvt_pkg::OP_CLEAR) ? kvt_pkg::S_ACT : kvt_pkg::S_SCAN;
        end
      end

      kvt_pkg::S_SCAN: begin
        // address stage
        cmp_vld_nxt = issue_r;
        if (issue_r) begin
          key_rd_en    = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
          cmp_last_nxt = (scan_idx_r == IDX_LAST);
          if (!valid_r[scan_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_idx_r;
          end
          if (scan_idx_r == IDX_LAST) begin
            issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + kvt_pkg::idx_t'(1);
          end
        end
        // compare stage, on the key read that the address stage registered
        if (cmp_vld_r) begin
          if (valid_r[cmp_idx_r] && key_rd_data == key_r) begin
            hit_nxt   = 1'b1;
            slot_nxt  = cmp_idx_r;
            state_nxt = kvt_pkg::S_ACT;
          end else if (cmp_last_r) begin
            state_nxt = kvt_pkg::S_ACT;
          end
        end
      end

      kvt_pkg::S_ACT: begin
        rd_nxt    = '0;
        st_nxt    = kvt_pkg::ST_OK;
        state_nxt = kvt_pkg::S_OUT;
        unique case (kind_r)
          kvt_pkg::OP_PUT: begin
            if (hit_r) begin
              val_wr_en = 1'b1;
            end else if (free_found_r && count_r < CNT_FULL) begin
              key_wr_en             = 1'b1;
              val_wr_en             = 1'b1;
              wr_addr               = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              count_nxt             = count_r + kvt_pkg::count_t'(1);
            end else begin
              st_nxt = kvt_pkg::ST_FULL;
            end
          end
          kvt_pkg::OP_REMOVE: begin
            if (hit_r) begin
              valid_nxt[slot_r] = 1'b0;
              if (count_r != '0) begin
                count_nxt = count_r - kvt_pkg::count_t'(1);
              end
            end else begin
              st_nxt = kvt_pkg::ST_NOT_FOUND;
            end
          end
          kvt_pkg::OP_GET: begin
            if (hit_r) begin
              val_rd_en = 1'b1;
              state_nxt = kvt_pkg::S_VDATA;
            end else begin
              st_nxt = kvt_pkg::ST_NOT_FOUND;
            end
          end
          kvt_pkg::OP_CLEAR: begin
            valid_nxt = '0;
            count_nxt = '0;
          end
          default: begin
            state_nxt = kvt_pkg::S_OUT;
          end
        endcase
      end

      kvt_pkg::S_VDATA: begin
        rd_nxt    = val_rd_data;
        state_nxt = kvt_pkg::S_OUT;
      end

      kvt_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_r;
          out_status_nxt = st_r;
          out_count_nxt  = count_r;
          out_empty_nxt  = (count_r == '0);
          state_nxt      = kvt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = kvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::S_IDLE;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_ch.kind;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    rd_r         <= rd_nxt;
    st_r         <= st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;

  // count must track the valid bits exactly
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) == $countones(valid_r))
    else $error("entry count differs from number of valid slots");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != kvt_pkg::S_IDLE)
    else $error("table idle right after accepting an item");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == kvt_pkg::ST_FULL |-> out_ch.entry_count == CNT_FULL)
    else $error("full status reported with free slots");

  // a put never removes a pair
  a_put_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kvt_pkg::S_ACT && kind_r == kvt_pkg::OP_PUT |=> count_r >= $past(count_r))
    else $error("put lowered the entry count");

endmodule

[tb/key_value_table_test.sv]
`timescale 1ns / 1ps
// key_value_table_test: self-checking bench for key_value_table.
// Drives put/remove/get/clear items with random gaps and checks every result item
// against a behavioral model of the table. Needs kvt_pkg, kvt_req_if, kvt_rsp_if.
module key_value_table_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 2 * kvt_pkg::ENTRIES + 8;
  localparam int MAX_SHOWN    = 10;
  localparam int QUIET_FROM   = 3000;
  localparam int QUIET_TO     = 5000;
  localparam int HOLD_AT_OP   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_SIZE    = 20;

  typedef struct {
    kvt_pkg::op_kind_t kind;
    kvt_pkg::key_t     key;
    kvt_pkg::value_t   value;
  } table_op_t;

  typedef struct {
    kvt_pkg::value_t  read_value;
    kvt_pkg::status_t status;
    kvt_pkg::count_t  entry_count;
    logic             is_empty;
  } table_result_t;

  typedef struct {
    table_op_t     op;
    table_result_t res;
  } table_check_t;

  logic clk;
  logic rst_n;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  key_value_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // model of the table contents
  kvt_pkg::key_t   slot_key   [kvt_pkg::ENTRIES];
  kvt_pkg::value_t slot_value [kvt_pkg::ENTRIES];
  bit              slot_used  [kvt_pkg::ENTRIES];
  int unsigned     used_count;

  table_op_t    pending_ops[$];
  table_check_t expected_results[$];

  int unsigned cycle_count;
  int unsigned ops_accepted;
  int unsigned mismatches;
  int unsigned op_tally [4];
  int unsigned full_seen;
  int unsigned missing_seen;
  int unsigned hold_left;
  bit          hold_done;

  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t r;
    int hit;
    int free_idx;
    r.read_value = '0;
    r.status     = kvt_pkg::ST_OK;
    hit          = -1;
    free_idx     = -1;
    // descending sweep leaves the lowest match and lowest free slot
    for (int i = kvt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == op.key) hit = i;
      if (!slot_used[i]) free_idx = i;
    end
    case (op.kind)
      kvt_pkg::OP_PUT: begin
        if (hit >= 0) begin
          slot_value[hit] = op.value;
        end else if (free_idx < 0) begin
          r.status = kvt_pkg::ST_FULL;
        end else begin
          slot_key[free_idx]   = op.key;
          slot_value[free_idx] = op.value;
          slot_used[free_idx]  = 1'b1;
          used_count++;
        end
      end
      kvt_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          used_count--;
        end else begin
          r.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      kvt_pkg::OP_GET: begin
        if (hit >= 0) r.read_value = slot_value[hit];
        else r.status = kvt_pkg::ST_NOT_FOUND;
      end
      default: begin
        for (int i = 0; i < kvt_pkg::ENTRIES; i++) slot_used[i] = 1'b0;
        used_count = 0;
      end
    endcase
    r.entry_count = kvt_pkg::count_t'(used_count);
    r.is_empty    = (used_count == 0);
    return r;
  endfunction

  function automatic bit take_break();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // driver: holds an item until accepted, then takes the next one
  always @(posedge clk) begin
    table_op_t    op;
    table_check_t chk;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        chk.op.kind  = req_ch.kind;
        chk.op.key   = req_ch.key;
        chk.op.value = req_ch.value;
        chk.res      = apply_table_op(chk.op);
        expected_results.insert(expected_results.size(), chk);
        op_tally[chk.op.kind]++;
        ops_accepted <= ops_accepted + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ops.size() > 0 && !take_break()) begin
          op = pending_ops.pop_front();
          req_ch.kind  <= op.kind;
          req_ch.key   <= op.key;
          req_ch.value <= op.value;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the table backs up and stalls the sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && ops_accepted >= HOLD_AT_OP) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor: compares each result item with the oldest expectation
  always @(posedge clk) begin
    table_check_t want;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result item: value=%h status=%0d count=%0d empty=%b",
                     rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count, rsp_ch.is_empty);
        end else begin
          want = expected_results.pop_front();
          if (want.res.status == kvt_pkg::ST_FULL) full_seen++;
          if (want.res.status == kvt_pkg::ST_NOT_FOUND) missing_seen++;
          if (rsp_ch.read_value !== want.res.read_value || rsp_ch.status !== want.res.status ||
              rsp_ch.entry_count !== want.res.entry_count ||
              rsp_ch.is_empty !== want.res.is_empty) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch %s key=%h: exp %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                       want.op.kind.name(), want.op.key,
                       want.res.read_value, want.res.status, want.res.entry_count,
                       want.res.is_empty, rsp_ch.read_value, rsp_ch.status,
                       rsp_ch.entry_count, rsp_ch.is_empty);
          end
        end
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !take_break();
      end
    end
  end

  task automatic queue_op(kvt_pkg::op_kind_t kind, kvt_pkg::key_t key,
                          kvt_pkg::value_t value);
    table_op_t op;
    op.kind  = kind;
    op.key   = key;
    op.value = value;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic wait_all_done();
    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // keys drawn mostly from a small pool so puts, gets and removes hit each other
  task automatic queue_random_segment(int n, bit fill_heavy);
    kvt_pkg::key_t     pool [POOL_SIZE];
    int unsigned       pick;
    kvt_pkg::op_kind_t kind;
    kvt_pkg::key_t     key;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (fill_heavy)
        kind = (pick < 60) ? kvt_pkg::OP_PUT : (pick < 80) ? kvt_pkg::OP_GET :
               (pick < 99) ? kvt_pkg::OP_REMOVE : kvt_pkg::OP_CLEAR;
      else
        kind = (pick < 30) ? kvt_pkg::OP_PUT : (pick < 60) ? kvt_pkg::OP_GET :
               (pick < 97) ? kvt_pkg::OP_REMOVE : kvt_pkg::OP_CLEAR;
      key = ($urandom_range(0, 9) == 0) ? kvt_pkg::key_t'($urandom())
                                        : pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_op(kind, key, kvt_pkg::value_t'($urandom()));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.kind  = kvt_pkg::OP_PUT;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    cycle_count  = 0;
    ops_accepted = 0;
    mismatches   = 0;
    full_seen    = 0;
    missing_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    used_count   = 0;
    for (int i = 0; i < 4; i++) op_tally[i] = 0;
    for (int i = 0; i < kvt_pkg::ENTRIES; i++) slot_used[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty-table cases, key/value extremes, update of an existing key
    queue_op(kvt_pkg::OP_CLEAR, '0, '1);
    queue_op(kvt_pkg::OP_GET, '1, '0);
    queue_op(kvt_pkg::OP_REMOVE, '0, '0);
    queue_op(kvt_pkg::OP_PUT, '0, '1);
    queue_op(kvt_pkg::OP_PUT, '1, '0);
    queue_op(kvt_pkg::OP_GET, '0, '1);
    queue_op(kvt_pkg::OP_GET, '1, '1);
    queue_op(kvt_pkg::OP_PUT, '0, 32'h5a5a_a5a5);
    queue_op(kvt_pkg::OP_GET, '0, '0);
    // fill up, then a new key into a full table and an update while full
    for (int i = 2; i < kvt_pkg::ENTRIES; i++)
      queue_op(kvt_pkg::OP_PUT, kvt_pkg::key_t'(32'h8000_0001 + i * 32'h0101_0101),
               kvt_pkg::value_t'(i));
    queue_op(kvt_pkg::OP_PUT, 32'h1234_5678, 32'hdead_beef);
    queue_op(kvt_pkg::OP_PUT, '1, 32'hffff_0000);
    queue_op(kvt_pkg::OP_GET, '1, '0);
    queue_op(kvt_pkg::OP_REMOVE, '0, '0);
    queue_op(kvt_pkg::OP_CLEAR, '0, '0);
    queue_op(kvt_pkg::OP_GET, '1, '0);
    wait_all_done();

    for (int s = 0; s < 13; s++) begin
      queue_random_segment(40, (s % 3) != 2);
      if (s == 6) wait_all_done();
    end

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d items: %0d put, %0d remove, %0d get, %0d clear",
             ops_accepted, op_tally[kvt_pkg::OP_PUT], op_tally[kvt_pkg::OP_REMOVE],
             op_tally[kvt_pkg::OP_GET], op_tally[kvt_pkg::OP_CLEAR]);
    $display("saw %0d table-full and %0d key-not-found results, %0d mismatches",
             full_seen, missing_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("key_value_table_test OK");
    else
      $display("key_value_table_test NOT OK");
    $finish;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycle_count);
    $display("key_value_table_test NOT OK");
    $finish;
  end

endmodule
